// ===== sv/ofst_pkg.sv =====
// Shared types and codes for the order fill/status table.
// Used by ofst_cell and order_fill_status_table_unit.
`default_nettype none

package ofst_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    localparam logic [1:0] ST_NEW      = 2'd0;
    localparam logic [1:0] ST_PART     = 2'd1;
    localparam logic [1:0] ST_FILLED   = 2'd2;
    localparam logic [1:0] ST_CANCELED = 2'd3;

    // Control part of an item traveling down the chain.
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
        logic       done;      // some cell already handled the item
        logic       accepted;
        logic       found;
        logic [1:0] state;
    } ofst_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ofst_cell.sv =====
// One table entry plus one stage of the item chain.
// Depends on ofst_pkg.
`default_nettype none

module ofst_cell
    import ofst_pkg::*;
#(
    parameter int KEY_BITS = 32,
    parameter int QTY_BITS = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire ofst_ctl_t           ctl_in,
    input  wire logic [KEY_BITS-1:0] key_in,
    input  wire logic [QTY_BITS-1:0] qty_in,
    input  wire logic [QTY_BITS-1:0] granted_in,
    input  wire logic [QTY_BITS-1:0] total_in,
    output ofst_ctl_t                ctl_out,
    output logic [KEY_BITS-1:0]      key_out,
    output logic [QTY_BITS-1:0]      qty_out,
    output logic [QTY_BITS-1:0]      granted_out,
    output logic [QTY_BITS-1:0]      total_out
);

    logic                ent_valid_reg, ent_valid_next;
    logic [KEY_BITS-1:0] ent_key_reg, ent_key_next;
    logic [QTY_BITS-1:0] ent_size_reg, ent_size_next;
    logic [QTY_BITS-1:0] ent_filled_reg, ent_filled_next;
    logic [1:0]          ent_state_reg, ent_state_next;

    ofst_ctl_t           ctl_reg, ctl_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [QTY_BITS-1:0] qty_reg;
    logic [QTY_BITS-1:0] granted_reg, granted_next;
    logic [QTY_BITS-1:0] total_reg, total_next;

    logic                live;
    logic                hit;
    logic                claim;
    logic [QTY_BITS-1:0] remain;
    logic [QTY_BITS-1:0] take;
    logic [QTY_BITS-1:0] sum;

    assign live   = ctl_in.valid && !ctl_in.done;
    assign hit    = live && ent_valid_reg && (key_in == ent_key_reg);
    // Entries fill in order, so the first empty cell seen means the key is absent.
    assign claim  = live && !ent_valid_reg && (ctl_in.cmd == CMD_ADD);
    assign remain = ent_size_reg - ent_filled_reg;
    assign take   = (qty_in < remain) ? qty_in : remain;
    assign sum    = ent_filled_reg + take;

    always_comb
    begin
        ent_valid_next  = ent_valid_reg;
        ent_key_next    = ent_key_reg;
        ent_size_next   = ent_size_reg;
        ent_filled_next = ent_filled_reg;
        ent_state_next  = ent_state_reg;
        ctl_next        = ctl_in;
        granted_next    = granted_in;
        total_next      = total_in;

        if (claim)
        begin
            ent_valid_next    = 1'b1;
            ent_key_next      = key_in;
            ent_size_next     = qty_in;
            ent_filled_next   = '0;
            ent_state_next    = ST_NEW;
            ctl_next.done     = 1'b1;
            ctl_next.accepted = 1'b1;
            ctl_next.found    = 1'b0;
            ctl_next.state    = ST_NEW;
            granted_next      = '0;
            total_next        = '0;
        end
        else if (hit)
        begin
            ctl_next.done  = 1'b1;
            ctl_next.found = 1'b1;
            unique case (ctl_in.cmd)
                CMD_ADD:
                begin
                    ent_size_next     = qty_in;
                    ent_filled_next   = '0;
                    ent_state_next    = ST_NEW;
                    ctl_next.accepted = 1'b1;
                end
                CMD_CANCEL:
                begin
                    if (ent_state_reg != ST_FILLED)
                    begin
                        ent_state_next    = ST_CANCELED;
                        ctl_next.accepted = 1'b1;
                    end
                end
                CMD_FILL:
                begin
                    if (ent_state_reg != ST_CANCELED && ent_state_reg != ST_FILLED)
                    begin
                        ent_filled_next   = sum;
                        ent_state_next    = (sum == ent_size_reg) ? ST_FILLED : ST_PART;
                        granted_next      = take;
                        ctl_next.accepted = 1'b1;
                    end
                end
                CMD_STATUS:
                begin
                    ctl_next.accepted = 1'b0;
                end
                default:
                begin
                    ctl_next.accepted = 1'b0;
                end
            endcase
            total_next     = ent_filled_next;
            ctl_next.state = ent_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            ctl_reg       <= '0;
        end
        else if (advance)
        begin
            ent_valid_reg <= ent_valid_next;
            ctl_reg       <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ent_key_reg    <= ent_key_next;
            ent_size_reg   <= ent_size_next;
            ent_filled_reg <= ent_filled_next;
            ent_state_reg  <= ent_state_next;
            key_reg        <= key_in;
            qty_reg        <= qty_in;
            granted_reg    <= granted_next;
            total_reg      <= total_next;
        end
    end

    assign ctl_out     = ctl_reg;
    assign key_out     = key_reg;
    assign qty_out     = qty_reg;
    assign granted_out = granted_reg;
    assign total_out   = total_reg;

endmodule

`default_nettype wire

// ===== sv/order_fill_status_table_unit.sv =====
// Top level of the order fill/status table: a chain of entry cells and a result register.
// Depends on ofst_pkg and ofst_cell.
//
//   channel  signals                                          direction
//   in       in_valid/in_ready: command, order_id, quantity   into block
//   out      out_valid/out_ready: accepted, found, table_full,
//            fill_granted, filled_total, order_state          out of block
//
// Each item walks the chain one cell per cycle while it advances, then enters the result
// register. One item per cycle is taken while the output register drains.
// A held result (out_valid high, out_ready low) freezes the whole chain and drops in_ready.
// Reset clears every entry's valid bit at once; no clearing pass is needed.
`default_nettype none

module order_fill_status_table_unit
    import ofst_pkg::*;
#(
    parameter int ORDER_SLOTS = 64,
    parameter int KEY_BITS    = 32,
    parameter int QTY_BITS    = 24
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          command,
    input  wire logic [KEY_BITS-1:0] order_id,
    input  wire logic [QTY_BITS-1:0] quantity,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     accepted,
    output logic                     found,
    output logic                     table_full,
    output logic [QTY_BITS-1:0]      fill_granted,
    output logic [QTY_BITS-1:0]      filled_total,
    output logic [1:0]               order_state
);

    ofst_ctl_t           ctl_w     [ORDER_SLOTS+1];
    logic [KEY_BITS-1:0] key_w     [ORDER_SLOTS+1];
    logic [QTY_BITS-1:0] qty_w     [ORDER_SLOTS+1];
    logic [QTY_BITS-1:0] granted_w [ORDER_SLOTS+1];
    logic [QTY_BITS-1:0] total_w   [ORDER_SLOTS+1];

    logic                advance;
    logic                out_valid_reg;
    logic                accepted_reg;
    logic                found_reg;
    logic                full_reg;
    logic [QTY_BITS-1:0] granted_reg;
    logic [QTY_BITS-1:0] total_reg;
    logic [1:0]          state_reg;
    ofst_ctl_t           last_ctl;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // valid, cmd, done, accepted, found, state
    assign ctl_w[0]     = {in_valid, command, 1'b0, 1'b0, 1'b0, ST_NEW};
    assign key_w[0]     = order_id;
    assign qty_w[0]     = quantity;
    assign granted_w[0] = '0;
    assign total_w[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ORDER_SLOTS; gi++)
        begin : g_cell
            ofst_cell #(
                .KEY_BITS (KEY_BITS),
                .QTY_BITS (QTY_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .advance     (advance),
                .ctl_in      (ctl_w[gi]),
                .key_in      (key_w[gi]),
                .qty_in      (qty_w[gi]),
                .granted_in  (granted_w[gi]),
                .total_in    (total_w[gi]),
                .ctl_out     (ctl_w[gi+1]),
                .key_out     (key_w[gi+1]),
                .qty_out     (qty_w[gi+1]),
                .granted_out (granted_w[gi+1]),
                .total_out   (total_w[gi+1])
            );
        end
    endgenerate

    assign last_ctl = ctl_w[ORDER_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= last_ctl.valid;
        end
    end

    // An add that no cell took means every entry is occupied.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            accepted_reg <= last_ctl.accepted;
            found_reg    <= last_ctl.found;
            full_reg     <= !last_ctl.done && (last_ctl.cmd == CMD_ADD);
            granted_reg  <= granted_w[ORDER_SLOTS];
            total_reg    <= total_w[ORDER_SLOTS];
            state_reg    <= last_ctl.state;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign found        = found_reg;
    assign table_full   = full_reg;
    assign fill_granted = granted_reg;
    assign filled_total = total_reg;
    assign order_state  = state_reg;

endmodule

`default_nettype wire
